[sv/ths_pkg.sv]
package ths_pkg;

    localparam int GRID_DIM_DEF    = 128;
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // per-stage control travelling down the query pipe
    typedef struct packed {
        logic vld;
        logic oor;
    } pipe_ctl_t;

endpackage

[sv/ths_bank.sv]
module ths_bank #(
    parameter int DEPTH = 4096,
    parameter int DW    = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ths_div.sv]
module ths_div #(
    parameter int FB = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [FB-1:0] num,
    input  logic [FB:0]   den,
    output logic [FB:0]   quo
);

    // restoring divider, one quotient bit per stage, num < den here
    // all stages hold together while en is low
    logic [FB:0]   rem_reg [FB+1];
    logic [FB:0]   den_reg [FB+1];
    logic [FB-1:0] q_reg   [FB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            for (int i = 0; i < FB; i++)
            begin
                if ({rem_reg[i], 1'b0} >= {1'b0, den_reg[i]})
                begin
                    rem_reg[i+1] <= (FB+1)'({rem_reg[i], 1'b0} - {1'b0, den_reg[i]});
                    q_reg[i+1]   <= {q_reg[i][FB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= {rem_reg[i][FB-1:0], 1'b0};
                    q_reg[i+1]   <= {q_reg[i][FB-2:0], 1'b0};
                end
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign quo = {1'b0, q_reg[FB]};

endmodule

[sv/terrain_height_sample.sv]
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | opcode row col height_value pos_x pos_z
// out     | out_valid | out_stall | height_out out_of_range
// cfg     | cfg_we    | -         | cfg_index cfg_data
// one item per cycle unless out_stall holds the pipe; a query passes the memory read,
// the stage 2 lerps, the divider pipe (one quotient bit per stage) and hout_reg
// four parity banks let all tile corners be read in the same cycle
// the whole pipe holds while out_stall is high with a result waiting
// reset clears control only; height map contents are undefined until written
module terrain_height_sample #(
    parameter int GRID_DIM    = ths_pkg::GRID_DIM_DEF,
    parameter int HEIGHT_BITS = ths_pkg::HEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = ths_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [6:0]                    row,
    input  logic [6:0]                    col,
    input  logic signed [HEIGHT_BITS-1:0] height_value,
    input  logic [14:0]                   pos_x,
    input  logic [14:0]                   pos_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            height_out,
    output logic                          out_of_range,
    input  logic                          cfg_we,
    input  logic [ths_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ths_pkg::CFG_W-1:0]     cfg_data
);

    localparam int FB  = FRAC_BITS;
    localparam int HB  = HEIGHT_BITS;
    localparam int GB  = $clog2(GRID_DIM);
    localparam int BD  = (GRID_DIM / 2) * (GRID_DIM / 2);
    localparam int BA  = $clog2(BD);
    localparam int IB  = 15 - FB;
    localparam int LAT = FB + 3;
    localparam int ONE = 1 << FB;

    // config registers
    logic [7:0] rows_reg, cols_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 8'd128;
            cols_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ths_pkg::REG_ROWS: rows_reg <= cfg_data;
                ths_pkg::REG_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advance
    logic adv;
    ths_pkg::pipe_ctl_t ctl_reg [LAT];
    assign adv      = !(ctl_reg[LAT-1].vld && out_stall);
    assign in_stall = !adv;

    logic acc;
    assign acc = in_valid && adv;

    // stage 0: decode, bank addressing
    logic [IB-1:0] xi, zi;
    logic [FB-1:0] fx, fz;
    assign xi = pos_x[14:FB];
    assign zi = pos_z[14:FB];
    assign fx = pos_x[FB-1:0];
    assign fz = pos_z[FB-1:0];

    logic [8:0] rows_e, cols_e;
    assign rows_e = (32'(rows_reg) > GRID_DIM) ? 9'(GRID_DIM) : {1'b0, rows_reg};
    assign cols_e = (32'(cols_reg) > GRID_DIM) ? 9'(GRID_DIM) : {1'b0, cols_reg};

    logic oor0;
    assign oor0 = (10'(xi) + 10'd1 >= 10'(cols_e)) || (10'(zi) + 10'd1 >= 10'(rows_e));

    // corner coordinates truncated to grid width (in range ones fit)
    logic [GB-1:0] x0, z0, x1, z1;
    assign x0 = GB'(xi);
    assign z0 = GB'(zi);
    assign x1 = GB'(xi + 1'b1);
    assign z1 = GB'(zi + 1'b1);

    // bank b = {zpar, xpar}; address = {z>>1, x>>1} for whichever corner has that parity
    logic [BA-1:0] raddr [4];
    logic [GB-1:0] cz [4], cx [4];
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            cz[b] = (z0[0] == b[1]) ? z0 : z1;
            cx[b] = (x0[0] == b[0]) ? x0 : x1;
            raddr[b] = BA'({cz[b][GB-1:1], cx[b][GB-1:1]});
        end
    end

    logic wr;
    logic [GB-1:0] wr_r, wr_c;
    assign wr   = acc && (opcode == ths_pkg::OP_WRITE)
                  && (32'(row) < GRID_DIM) && (32'(col) < GRID_DIM);
    assign wr_r = GB'(row);
    assign wr_c = GB'(col);

    logic [BA-1:0] raddr1_reg [4];
    logic [HB-1:0] rd [4];
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);
        ths_bank #(.DEPTH(BD), .DW(HB)) u_bank (
            .clk   (clk),
            .we    (wr && wr_r[0] == BSEL[1] && wr_c[0] == BSEL[0]),
            .waddr (BA'({wr_r[GB-1:1], wr_c[GB-1:1]})),
            .wdata (height_value),
            .raddr (adv ? raddr[b] : raddr1_reg[b]),
            .rdata (rd[b])
        );
    end

    // stage 1 registers (read in flight); hold read address on stall
    logic [FB-1:0] fx1_reg, fz1_reg;
    logic          xp1_reg, zp1_reg;
    logic          q1;
    assign q1 = acc && (opcode == ths_pkg::OP_QUERY);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raddr1_reg <= raddr;
            fx1_reg    <= fx;
            fz1_reg    <= fz;
            xp1_reg    <= x0[0];
            zp1_reg    <= z0[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= '{vld: q1, oor: oor0};
            for (int i = 1; i < LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // stage 2: pick corners, triangle, edge lerps
    logic signed [HB-1:0] h00, h01, h10, h11;
    always_comb
    begin
        h00 = rd[{zp1_reg, xp1_reg}];
        h01 = rd[{zp1_reg, ~xp1_reg}];
        h10 = rd[{~zp1_reg, xp1_reg}];
        h11 = rd[{~zp1_reg, ~xp1_reg}];
    end

    logic signed [HB-1:0] pa, qa, pb, qb;
    logic signed [FB+1:0] num;
    logic        [FB:0]   den;
    logic                 sum_hi, dpos, dneg, slant, lower;
    logic signed [FB+1:0] sfx, sfz;
    always_comb
    begin
        sfx    = (FB+2)'(fx1_reg);
        sfz    = (FB+2)'(fz1_reg);
        sum_hi = (sfx + sfz) >= (FB+2)'(ONE);
        dpos   = sfx > sfz;
        dneg   = sfx < sfz;
        slant  = xp1_reg ^ zp1_reg;
        if (!slant)
        begin
            lower = sum_hi;
            if (!lower)
            begin
                pa = h00; qa = h01; pb = h10; qb = h01;
                num = sfz; den = (FB+1)'(ONE) - (FB+1)'(fx1_reg);
            end
            else
            begin
                pa = h10; qa = h01; pb = h10; qb = h11;
                num = sfz + sfx - (FB+2)'(ONE); den = (FB+1)'(fx1_reg);
            end
        end
        else
        begin
            lower = sum_hi ? dneg : !dpos;
            if (!lower)
            begin
                pa = h00; qa = h01; pb = h00; qb = h11;
                num = sfz; den = (FB+1)'(fx1_reg);
            end
            else
            begin
                pa = h10; qa = h11; pb = h00; qb = h11;
                num = (FB+2)'(ONE) - sfz; den = (FB+1)'(ONE) - (FB+1)'(fx1_reg);
            end
        end
    end

    // edge lerp: p + floor((q-p)*f / ONE)
    logic signed [HB+FB+2:0] ma, mb;
    assign ma = (HB+FB+3)'(qa - pa) * $signed({2'b0, fx1_reg});
    assign mb = (HB+FB+3)'(qb - pb) * $signed({2'b0, fx1_reg});

    logic signed [HB+1:0] a2_reg, b2_reg;
    logic                 tz2_reg, t1_2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg   <= (HB+2)'(pa) + (HB+2)'(ma >>> FB);
            b2_reg   <= (HB+2)'(pb) + (HB+2)'(mb >>> FB);
            tz2_reg  <= num <= 0;
            t1_2_reg <= !(num <= 0) && (num >= $signed({1'b0, den}));
        end
    end

    // divider: enters with stage 2 values, needs num < den
    logic [FB:0] quo;
    ths_div #(.FB(FB)) u_div (
        .clk    (clk),
        .en     (adv),
        .num    (FB'(num)),
        .den    (den),
        .quo    (quo)
    );

    // delay lerp results alongside divider
    logic signed [HB+1:0] ad_reg [FB], bd_reg [FB];
    logic [FB-1:0]        tz_d, t1_d;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ad_reg[0] <= a2_reg;
            bd_reg[0] <= b2_reg;
            tz_d[0]   <= tz2_reg;
            t1_d[0]   <= t1_2_reg;
            for (int i = 1; i < FB; i++)
            begin
                ad_reg[i] <= ad_reg[i-1];
                bd_reg[i] <= bd_reg[i-1];
                tz_d[i]   <= tz_d[i-1];
                t1_d[i]   <= t1_d[i-1];
            end
        end
    end

    // final lerp and saturate
    logic [FB:0] t;
    assign t = tz_d[FB-1] ? '0 : (t1_d[FB-1] ? (FB+1)'(ONE) : quo);

    logic signed [HB+FB+3:0] mf;
    logic signed [HB+2:0]    hf;
    logic signed [HB-1:0]    hs;
    assign mf = (HB+FB+4)'(bd_reg[FB-1] - ad_reg[FB-1]) * $signed({1'b0, t});
    assign hf = (HB+3)'(ad_reg[FB-1]) + (HB+3)'(mf >>> FB);
    always_comb
    begin
        if (hf > (HB+3)'((1 << (HB-1)) - 1))
        begin
            hs = {1'b0, {(HB-1){1'b1}}};
        end
        else if (hf < -(HB+3)'(1 << (HB-1)))
        begin
            hs = {1'b1, {(HB-1){1'b0}}};
        end
        else
        begin
            hs = HB'(hf);
        end
    end

    logic [15:0] hout_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hout_reg <= ctl_reg[LAT-2].oor ? 16'd0 : 16'(hs);
        end
    end

    assign out_valid    = ctl_reg[LAT-1].vld;
    assign out_of_range = ctl_reg[LAT-1].oor;
    assign height_out   = hout_reg;

    // assertions
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(height_out)))
        else $error("result changed under stall");
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (height_out == 16'd0))
        else $error("out of range result not zero");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without cause");

endmodule

[sim/height_checker.sv]
module height_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               opcode,
    input  logic [6:0]         row,
    input  logic [6:0]         col,
    input  logic signed [15:0] height_value,
    input  logic [14:0]        pos_x,
    input  logic [14:0]        pos_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] height_out,
    input  logic               out_of_range,
    input  logic               cfg_we,
    input  logic [ths_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ths_pkg::CFG_W-1:0]     cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int ONE  = 1 << ths_pkg::FRAC_BITS_DEF;
    localparam int GRID = ths_pkg::GRID_DIM_DEF;

    typedef struct {
        logic signed [15:0] height;
        logic               oor;
    } height_result_t;

    logic signed [15:0] shadow_map [0:GRID*GRID-1];
    int unsigned        rows_cfg;
    int unsigned        cols_cfg;
    height_result_t     expected_heights [$];

    assign pending = expected_heights.size();

    // append one expected result at the tail
    function automatic void enqueue_expected(height_result_t r);
        expected_heights.insert(expected_heights.size(), r);
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint mix(longint p, longint q, longint f);
        return p + fdiv((q - p) * f, ONE);
    endfunction

    function automatic longint corner(int unsigned r, int unsigned c);
        return longint'(shadow_map[r * GRID + c]);
    endfunction

    // triangle interpolation of one query
    function automatic height_result_t interpolate_height(logic [14:0] px, logic [14:0] pz);
        height_result_t res;
        int unsigned    nr, nc, x, z;
        longint         fx, fz, a, b, t, num, den, h;
        bit             upper_left, north_east, odd_tile;
        nr = (rows_cfg > GRID) ? GRID : rows_cfg;
        nc = (cols_cfg > GRID) ? GRID : cols_cfg;
        x = 32'(px >> ths_pkg::FRAC_BITS_DEF);
        z = 32'(pz >> ths_pkg::FRAC_BITS_DEF);
        fx = longint'(px[7:0]);
        fz = longint'(pz[7:0]);
        res.height = '0;
        res.oor = 1'b1;
        if (x + 1 >= nc || z + 1 >= nr)
            return res;
        // quadrant: north/west when s < ONE
        if (fx + fz < ONE)
        begin
            upper_left = 1;
            north_east = (fx - fz > 0);
        end
        else
        begin
            upper_left = 0;
            north_east = !(fx - fz < 0);
        end
        odd_tile = ((x + z) & 1) != 0;
        if (!odd_tile)
        begin
            if (upper_left)
            begin
                a = mix(corner(z, x), corner(z, x + 1), fx);
                b = mix(corner(z + 1, x), corner(z, x + 1), fx);
                num = fz;
                den = ONE - fx;
            end
            else
            begin
                a = mix(corner(z + 1, x), corner(z, x + 1), fx);
                b = mix(corner(z + 1, x), corner(z + 1, x + 1), fx);
                num = fz + fx - ONE;
                den = fx;
            end
        end
        else
        begin
            // north and east are the upper triangle of an odd tile
            if ((upper_left && north_east) || (!upper_left && north_east))
            begin
                a = mix(corner(z, x), corner(z, x + 1), fx);
                b = mix(corner(z, x), corner(z + 1, x + 1), fx);
                num = fz;
                den = fx;
            end
            else
            begin
                a = mix(corner(z + 1, x), corner(z + 1, x + 1), fx);
                b = mix(corner(z, x), corner(z + 1, x + 1), fx);
                num = ONE - fz;
                den = ONE - fx;
            end
        end
        if (num <= 0)
            t = 0;
        else if (num >= den)
            t = ONE;
        else
            t = fdiv(num * ONE, den);
        h = mix(a, b, t);
        if (h > 32767)
            h = 32767;
        if (h < -32768)
            h = -32768;
        res.height = h[15:0];
        res.oor = 1'b0;
        return res;
    endfunction

    // track config, map writes and queries
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg <= 128;
            cols_cfg <= 128;
        end
        else
        begin
            if (cfg_we && cfg_index == ths_pkg::REG_ROWS)
                rows_cfg <= 32'(cfg_data);
            if (cfg_we && cfg_index == ths_pkg::REG_COLS)
                cols_cfg <= 32'(cfg_data);
            if (in_valid && !in_stall)
            begin
                if (opcode == ths_pkg::OP_WRITE)
                    shadow_map[row * GRID + col] = height_value;
                else
                    enqueue_expected(interpolate_height(pos_x, pos_z));
            end
        end
    end

    // compare results
    always @(posedge clk or negedge rst_n)
    begin
        height_result_t exp_r;
        if (!rst_n)
            fail_count <= 0;
        else if (out_valid && !out_stall)
        begin
            if (expected_heights.size() == 0)
            begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("unexpected result: height %0d oor %0d", height_out,
                             out_of_range);
            end
            else
            begin
                exp_r = expected_heights.pop_front();
                if (exp_r.height !== height_out || exp_r.oor !== out_of_range)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("mismatch: exp height %0d oor %0d, got height %0d oor %0d",
                                 exp_r.height, exp_r.oor, height_out, out_of_range);
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
module tb_top;

    localparam int LATENCY = ths_pkg::FRAC_BITS_DEF + 3;
    localparam int WATCHDOG = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               opcode;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] height_value;
    logic [14:0]        pos_x;
    logic [14:0]        pos_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] height_out;
    logic               out_of_range;
    logic               cfg_we;
    logic [ths_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ths_pkg::CFG_W-1:0]     cfg_data;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 quiet_cycles;
    int unsigned        rows_now;
    int unsigned        cols_now;

    terrain_height_sample dut (.*);

    height_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stalls
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog on accepts
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // present one item and wait for its accept
    task automatic send_item(logic op, logic [6:0] r, logic [6:0] c, logic [15:0] hv,
                             logic [14:0] px, logic [14:0] pz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        row <= r;
        col <= c;
        height_value <= hv;
        pos_x <= px;
        pos_z <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_cell(int unsigned r, int unsigned c, logic [15:0] hv);
        send_item(ths_pkg::OP_WRITE, r[6:0], c[6:0], hv, 15'($urandom), 15'($urandom));
    endtask

    task automatic query_at(logic [14:0] px, logic [14:0] pz);
        send_item(ths_pkg::OP_QUERY, 7'($urandom), 7'($urandom), 16'($urandom), px, pz);
    endtask

    // drain, then write both registers
    task automatic set_grid(int unsigned nr, int unsigned nc);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ths_pkg::REG_ROWS;
        cfg_data <= 8'(nr);
        @(posedge clk);
        cfg_index <= ths_pkg::REG_COLS;
        cfg_data <= 8'(nc);
        @(posedge clk);
        cfg_we <= 1'b0;
        rows_now = nr;
        cols_now = nc;
    endtask

    // random in-range query over the written block
    task automatic random_query(int unsigned span);
        int unsigned x, z;
        x = $urandom_range(span - 2);
        z = $urandom_range(span - 2);
        query_at({x[6:0], 8'($urandom)}, {z[6:0], 8'($urandom)});
    endtask

    // query whose tile lies past the grid in use
    task automatic outside_query();
        int unsigned x, z;
        x = $urandom_range(127);
        z = $urandom_range(127);
        if ($urandom_range(1) == 0)
            x = $urandom_range(127, cols_now - 1);
        else
            z = $urandom_range(127, rows_now - 1);
        query_at({x[6:0], 8'($urandom)}, {z[6:0], 8'($urandom)});
    endtask

    initial
    begin
        int unsigned span;
        in_valid = 1'b0;
        opcode = ths_pkg::OP_WRITE;
        row = '0;
        col = '0;
        height_value = '0;
        pos_x = '0;
        pos_z = '0;
        cfg_we = 1'b0;
        cfg_index = ths_pkg::REG_ROWS;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rows_now = 128;
        cols_now = 128;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes around the far corner and origin
        write_cell(0, 0, 16'h7fff);
        write_cell(0, 1, 16'h8000);
        write_cell(1, 0, 16'h8000);
        write_cell(1, 1, 16'h7fff);
        write_cell(1, 2, 16'h0100);
        write_cell(0, 2, 16'hff00);
        write_cell(126, 126, 16'h7fff);
        write_cell(126, 127, 16'h8000);
        write_cell(127, 126, 16'h1234);
        write_cell(127, 127, 16'hedcb);
        query_at(15'h0000, 15'h0000);
        query_at(15'h00ff, 15'h00ff);
        query_at(15'h00c0, 15'h0010);
        query_at(15'h0010, 15'h00c0);
        query_at(15'h0080, 15'h0080);
        query_at(15'h01ff, 15'h0001);
        query_at(15'h0180, 15'h0020);
        query_at(15'h7eff, 15'h7eff);
        query_at(15'h7e00, 15'h7e80);
        query_at(15'h7f00, 15'h0000);
        query_at(15'h7fff, 15'h7fff);
        query_at(15'h0000, 15'h7f00);
        set_grid(2, 2);
        query_at(15'h00ff, 15'h0000);
        query_at(15'h0100, 15'h0000);
        set_grid(255, 255);
        query_at(15'h7eff, 15'h7eff);
        query_at(15'h7f00, 15'h0000);

        // random phases: fill a block, then mostly queries
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            span = (ph == 5) ? 128 : $urandom_range(2, 12);
            set_grid(ph == 5 ? 128 : $urandom_range(span, span + 3),
                     ph == 5 ? 128 : $urandom_range(span, span + 3));
            for (int r = 0; r < span && r < 12; r++)
                for (int c = 0; c < span && c < 12; c++)
                    write_cell(r, c, 16'($urandom));
            if (span > 12)
                span = 12;
            for (int k = 0; k < 70; k++)
            begin
                case ($urandom_range(9))
                    0: write_cell($urandom_range(span - 1), $urandom_range(span - 1),
                                  16'($urandom));
                    1: outside_query();
                    default: random_query(span);
                endcase
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
